// File: sv/frc_pkg.sv
package frc_pkg;

	// Request codes
	typedef enum logic [1:0] {
		REQ_FRAG  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} frc_req_e;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_FRAG = 3'd1,
		ST_BAD_LEN  = 3'd2,
		ST_BAD_MAG  = 3'd3,
		ST_BAD_CRC  = 3'd4
	} frc_status_e;

	localparam int          ENV_BYTES   = 8;
	localparam int          HDR_BYTES   = 14;
	localparam int          CRC_BYTES   = 2;
	localparam int          MIN_FRAME   = HDR_BYTES + CRC_BYTES;
	localparam int          CRC_SKIP    = 4;
	localparam logic [15:0] FRAME_MAGIC = 16'hB17E;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_MSB     = 16'h8000;
	localparam logic [16:0] CNT_MAX     = 17'h1FFFF;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [10:0] read_index;
	} frc_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        complete;
		logic [10:0] frm_len;
		logic [7:0]  ver_major;
		logic [7:0]  ver_minor;
		logic [7:0]  msg_kind;
		logic [7:0]  flag_bits;
		logic [15:0] frame_sequence;
		logic [31:0] time_ms;
		logic [10:0] pay_len;
		logic [7:0]  read_data;
	} frc_rsp_t;

	// Result on its way to the output register
	typedef struct packed {
		frc_rsp_t res;
		logic     is_read;
		logic     rd_oor;
	} frc_stage_t;

	// CRC-16/CCITT-FALSE, one byte
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((r & CRC_MSB) != 16'h0000)
				r = (r << 1) ^ CRC_POLY;
			else
				r = r << 1;
		end
		return r;
	endfunction

endpackage

// File: sv/frc_ram.sv
module frc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2080
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: sv/frc_result_stage.sv
module frc_result_stage import frc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frc_stage_t push_data,
	output logic       ready,
	input  logic [7:0] ram_rdata,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output frc_rsp_t   rsp
);

	logic       s1_valid_s1;
	frc_stage_t data_s1;
	logic       adv;
	frc_rsp_t   res_s1;

	assign adv   = !rsp_valid || rsp_ready;
	assign ready = !s1_valid_s1 || adv;

	// Store byte arrives in the cycle after the read was issued
	always_comb begin
		res_s1 = data_s1.res;
		if (data_s1.is_read && !data_s1.rd_oor)
			res_s1.read_data = ram_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			rsp_valid   <= 1'b0;
		end else begin
			if (adv)
				rsp_valid <= s1_valid_s1;
			if (ready)
				s1_valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_s1)
			rsp <= res_s1;
		if (ready && push)
			data_s1 <= push_data;
	end

endmodule

// File: sv/fragment_reassembler_frame_checker.sv
// Fragment reassembler and frame checker. Takes one request per cycle while req_ready is
// high: a fragment byte, a read of the held frame, or a clear. Fragments carry an 8-byte
// little-endian envelope (sequence, index, count, data length) and their data goes into a
// two-bank frame store; index 0 fills the spare bank so a rejected start leaves the held
// frame intact. The last byte of every fragment and every read give one result, passed
// through a staging register and then the output register; other requests give none.
// Sustained rate is one request per cycle while results are taken; a stalled result can
// hold off new requests. The store is not cleared: reading a byte never written is undefined.
module fragment_reassembler_frame_checker import frc_pkg::*; #(
	parameter int MAX_PAYLOAD = 1024,
	parameter int MAX_FRAME   = 1040
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  frc_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output frc_rsp_t rsp
);

	localparam int LEN_W = $clog2(MAX_FRAME + 1);
	localparam int DEPTH = 2 * MAX_FRAME;
	localparam int AW    = $clog2(DEPTH);
	localparam int POS_W = 18;

	logic [16:0]      cnt_q;
	logic [63:0]      env_q;
	logic             active_q;
	logic [15:0]      hseq_q, hcnt_q, exp_q;
	logic [LEN_W-1:0] len_q;
	logic             bank_q;
	logic [15:0]      ccrc_q, wcrc_q, lag_q, raw_q, ctail_q;
	logic [7:0]       hdr_q [2][HDR_BYTES];

	logic             acc, is_frag, is_read, is_clear;
	logic [63:0]      env_nx;
	logic [15:0]      seq_n, idx_n, cnt_n, dlen_n;
	logic             first, may_wr, wr_ok, wr, wbank;
	logic [POS_W-1:0] off, base, pos, n;
	logic [AW-1:0]    waddr, raddr;
	logic [15:0]      wcrc_nx, lag_nx, raw_nx;
	logic             bad_env, match, ovf, done, bank_new;
	logic [16:0]      sum;
	logic [LEN_W-1:0] len_new;
	logic [15:0]      exp_new, hcnt_eff, magic, pl, rx;
	logic             stage_ready, push, rd_oor;
	frc_rsp_t         res;
	frc_stage_t       stage;
	logic [7:0]       ram_rdata;

	assign acc      = req_valid && req_ready;
	assign is_frag  = req.req_type == REQ_FRAG;
	assign is_read  = req.req_type == REQ_READ;
	assign is_clear = req.req_type == REQ_CLEAR;

	// Envelope capture
	always_comb begin
		env_nx = env_q;
		if (cnt_q < 17'(ENV_BYTES))
			env_nx = (cnt_q == 17'd0 ? 64'd0 : env_q) |
				(64'(req.data_byte) << {cnt_q[2:0], 3'b000});
	end
	assign seq_n  = env_nx[15:0];
	assign idx_n  = env_nx[31:16];
	assign cnt_n  = env_nx[47:32];
	assign dlen_n = env_nx[63:48];
	assign first  = idx_n == 16'd0;

	// Data byte placement
	assign may_wr = cnt_n != 16'd0 && idx_n < cnt_n && (first || (active_q &&
		seq_n == hseq_q && cnt_n == hcnt_q && idx_n == exp_q));
	assign off   = POS_W'(cnt_q) - POS_W'(ENV_BYTES);
	assign base  = first ? '0 : POS_W'(len_q);
	assign pos   = base + off;
	assign wr_ok = cnt_q >= 17'(ENV_BYTES) && may_wr && off < POS_W'(dlen_n) &&
		pos < POS_W'(MAX_FRAME);
	assign wr    = acc && is_frag && wr_ok;
	assign wbank = first ? !bank_q : bank_q;
	assign waddr = AW'(pos) + (wbank ? AW'(MAX_FRAME) : AW'(0));

	// Running CRC with two-byte lag, true store tail
	always_comb begin
		wcrc_nx = wcrc_q;
		lag_nx  = lag_q;
		raw_nx  = raw_q;
		if (cnt_q == 17'(ENV_BYTES - 1)) begin
			if (first) begin
				wcrc_nx = CRC_INIT;
				lag_nx  = '0;
				raw_nx  = '0;
			end else begin
				wcrc_nx = ccrc_q;
				lag_nx  = (len_q >= LEN_W'(2)) ? ctail_q : '0;
				raw_nx  = ctail_q;
			end
		end else if (wr_ok) begin
			if (pos >= POS_W'(CRC_SKIP))
				wcrc_nx = crc_feed(wcrc_q, lag_q[15:8]);
			lag_nx = {lag_q[7:0], req.data_byte};
			raw_nx = {raw_q[7:0], req.data_byte};
		end
	end

	// End of fragment decisions
	assign n        = POS_W'(cnt_q) + POS_W'(1);
	assign bad_env  = n < POS_W'(ENV_BYTES) || cnt_n == 16'd0 || idx_n >= cnt_n ||
		POS_W'(dlen_n) != n - POS_W'(ENV_BYTES);
	assign match    = first || (seq_n == hseq_q && cnt_n == hcnt_q && idx_n == exp_q);
	assign sum      = 17'(first ? LEN_W'(0) : len_q) + 17'(dlen_n);
	assign ovf      = sum > 17'(MAX_FRAME);
	assign len_new  = LEN_W'(sum);
	assign exp_new  = (first ? 16'd0 : exp_q) + 16'd1;
	assign hcnt_eff = first ? cnt_n : hcnt_q;
	assign done     = exp_new >= hcnt_eff;
	assign bank_new = first ? !bank_q : bank_q;
	assign magic    = {hdr_q[bank_new][1], hdr_q[bank_new][0]};
	assign pl       = {hdr_q[bank_new][13], hdr_q[bank_new][12]};
	assign rx       = {lag_nx[7:0], lag_nx[15:8]};

	// Result fields
	always_comb begin
		res = '0;
		if (is_frag) begin
			if (bad_env || !(first || active_q) || !match)
				res.status = ST_BAD_FRAG;
			else if (ovf)
				res.status = ST_BAD_LEN;
			else if (done) begin
				if (len_new < LEN_W'(MIN_FRAME))
					res.status = ST_BAD_LEN;
				else if (magic != FRAME_MAGIC)
					res.status = ST_BAD_MAG;
				else if (pl > 16'(MAX_PAYLOAD) ||
					17'(len_new) != 17'(pl) + 17'(MIN_FRAME))
					res.status = ST_BAD_LEN;
				else if (rx != wcrc_nx)
					res.status = ST_BAD_CRC;
				else begin
					res.status         = ST_OK;
					res.complete       = 1'b1;
					res.frm_len        = 11'(len_new);
					res.ver_major      = hdr_q[bank_new][2];
					res.ver_minor      = hdr_q[bank_new][3];
					res.msg_kind       = hdr_q[bank_new][4];
					res.flag_bits      = hdr_q[bank_new][5];
					res.frame_sequence = {hdr_q[bank_new][7], hdr_q[bank_new][6]};
					res.time_ms        = {hdr_q[bank_new][11], hdr_q[bank_new][10],
						hdr_q[bank_new][9], hdr_q[bank_new][8]};
					res.pay_len        = 11'(pl);
				end
			end
		end
	end

	// Control and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			env_q    <= '0;
			active_q <= 1'b0;
			hseq_q   <= '0;
			hcnt_q   <= '0;
			exp_q    <= '0;
			len_q    <= '0;
			bank_q   <= 1'b0;
			ccrc_q   <= CRC_INIT;
			wcrc_q   <= CRC_INIT;
			lag_q    <= '0;
			raw_q    <= '0;
			ctail_q  <= '0;
		end else if (acc && is_clear) begin
			cnt_q    <= '0;
			env_q    <= '0;
			active_q <= 1'b0;
			hseq_q   <= '0;
			hcnt_q   <= '0;
			exp_q    <= '0;
			len_q    <= '0;
			bank_q   <= 1'b0;
			ccrc_q   <= CRC_INIT;
			wcrc_q   <= CRC_INIT;
			lag_q    <= '0;
			raw_q    <= '0;
			ctail_q  <= '0;
		end else if (acc && is_frag) begin
			env_q  <= env_nx;
			wcrc_q <= wcrc_nx;
			lag_q  <= lag_nx;
			raw_q  <= raw_nx;
			if (!req.last_byte) begin
				if (cnt_q < CNT_MAX)
					cnt_q <= cnt_q + 17'd1;
			end else begin
				cnt_q <= '0;
				if (!bad_env && (first || active_q)) begin
					if (first) begin
						hseq_q <= seq_n;
						hcnt_q <= cnt_n;
						exp_q  <= '0;
					end
					if (!match || ovf) begin
						active_q <= 1'b0;
						len_q    <= '0;
					end else begin
						bank_q   <= bank_new;
						len_q    <= len_new;
						ccrc_q   <= wcrc_nx;
						ctail_q  <= raw_nx;
						exp_q    <= exp_new;
						active_q <= !done;
					end
				end
			end
		end
	end

	// Header shadow of both store banks
	always_ff @(posedge clk) begin
		if (wr && pos < POS_W'(HDR_BYTES))
			hdr_q[wbank][4'(pos)] <= req.data_byte;
	end

	// Frame store
	assign rd_oor = 32'(req.read_index) >= 32'(MAX_FRAME);
	assign raddr  = rd_oor ? AW'(0) :
		AW'(req.read_index) + (bank_q ? AW'(MAX_FRAME) : AW'(0));

	frc_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr),
		.waddr(waddr),
		.wdata(req.data_byte),
		.re   (acc && is_read),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// Result path
	assign push          = acc && (is_read || (is_frag && req.last_byte));
	assign stage.res     = res;
	assign stage.is_read = is_read;
	assign stage.rd_oor  = rd_oor;
	assign req_ready     = stage_ready;

	frc_result_stage u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(stage),
		.ready    (stage_ready),
		.ram_rdata(ram_rdata),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

// File: sv/frc_checker.sv
module frc_checker import frc_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input frc_req_t req,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input frc_rsp_t rsp
);

	// Stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Header fields only on a complete frame
	a_incomplete_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.complete |-> rsp.frm_len == 11'd0 &&
		rsp.time_ms == 32'd0 && rsp.pay_len == 11'd0)
		else $error("header fields set without complete");

	// Complete frames are always good
	a_complete_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.complete |-> rsp.status == ST_OK && rsp.read_data == 8'd0)
		else $error("complete with bad status or read data");

	// No result comes out of reset
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("result valid during reset");

endmodule

bind fragment_reassembler_frame_checker frc_checker u_frc_checker (.*);

// File: sim/frc_frame_scoreboard.sv
`timescale 1ns / 100ps

// Watches both channels, predicts every result and compares it with the block's output.
module frc_frame_scoreboard import frc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  frc_req_t          req,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  frc_rsp_t          rsp,
	output int                errors,
	output int                pending,
	output int                results_seen,
	output int                frames_ok,
	output logic [2079:0]     written,
	output logic              held_bank
);

	localparam int MAX_PAYLOAD = 1024;
	localparam int MAX_FRAME   = 1040;

	// Predicted reassembly state
	logic [16:0]  frag_cnt;
	logic [63:0]  env;
	logic         active;
	logic [15:0]  held_seq;
	logic [15:0]  held_cnt;
	logic [15:0]  next_idx;
	int unsigned  held_len;
	logic [7:0]   store_mem [0:2*MAX_FRAME-1];
	logic [15:0]  crc_held;
	logic [15:0]  crc_run;
	logic [15:0]  tail_bytes;

	frc_rsp_t     expected_rsp_q [$];
	frc_rsp_t     exp_rsp;
	frc_rsp_t     pred_rsp;
	bit           pred_has;

	initial begin
		errors       = 0;
		results_seen = 0;
		frames_ok    = 0;
		pending      = 0;
	end

	function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		return r;
	endfunction

	function automatic logic [15:0] env_word(int n);
		return env[16*n +: 16];
	endfunction

	function automatic logic [7:0] held_byte(int unsigned pos);
		if (pos >= MAX_FRAME)
			return 8'h00;
		return store_mem[int'(held_bank) * MAX_FRAME + pos];
	endfunction

	// Envelope lets data be staged into the store
	function automatic bit staging_ok();
		logic [15:0] seq, idx, cnt;
		seq = env_word(0);
		idx = env_word(1);
		cnt = env_word(2);
		if (cnt == 0 || idx >= cnt)
			return 0;
		if (idx == 0)
			return 1;
		return active && seq == held_seq && cnt == held_cnt && idx == next_idx;
	endfunction

	task automatic wipe_state();
		frag_cnt   = '0;
		env        = '0;
		active     = 0;
		held_seq   = '0;
		held_cnt   = '0;
		next_idx   = '0;
		held_len   = 0;
		held_bank  = 0;
		crc_held   = CRC_INIT;
		crc_run    = CRC_INIT;
		tail_bytes = '0;
		written    = '0;
	endtask

	// Frame check on the held frame
	task automatic check_frame(inout frc_rsp_t o);
		int unsigned pl;
		logic [15:0] rx;
		if (held_len < MIN_FRAME) begin
			o.status = ST_BAD_LEN;
			return;
		end
		if ({held_byte(1), held_byte(0)} != FRAME_MAGIC) begin
			o.status = ST_BAD_MAG;
			return;
		end
		pl = {held_byte(13), held_byte(12)};
		if (pl > MAX_PAYLOAD || held_len != HDR_BYTES + pl + CRC_BYTES) begin
			o.status = ST_BAD_LEN;
			return;
		end
		rx = {tail_bytes[7:0], tail_bytes[15:8]};
		if (rx != crc_held) begin
			o.status = ST_BAD_CRC;
			return;
		end
		o.complete       = 1'b1;
		o.frm_len        = held_len[10:0];
		o.ver_major      = held_byte(2);
		o.ver_minor      = held_byte(3);
		o.msg_kind       = held_byte(4);
		o.flag_bits      = held_byte(5);
		o.frame_sequence = {held_byte(7), held_byte(6)};
		o.time_ms        = {held_byte(11), held_byte(10), held_byte(9), held_byte(8)};
		o.pay_len        = pl[10:0];
	endtask

	// Envelope and sequence checks at the last byte of a fragment
	task automatic close_fragment(int unsigned n, inout frc_rsp_t o);
		logic [15:0] seq, idx, cnt, dlen;
		o.status = ST_BAD_FRAG;
		if (n < ENV_BYTES)
			return;
		seq  = env_word(0);
		idx  = env_word(1);
		cnt  = env_word(2);
		dlen = env_word(3);
		if (cnt == 0 || idx >= cnt || dlen != n - ENV_BYTES)
			return;
		if (idx == 0) begin
			held_len = 0;
			held_seq = seq;
			held_cnt = cnt;
			next_idx = '0;
			active   = 1;
		end
		if (!active)
			return;
		if (seq != held_seq || cnt != held_cnt || idx != next_idx) begin
			active   = 0;
			held_len = 0;
			return;
		end
		if (held_len + dlen > MAX_FRAME) begin
			active   = 0;
			held_len = 0;
			o.status = ST_BAD_LEN;
			return;
		end
		if (idx == 0)
			held_bank = !held_bank;
		held_len += dlen;
		crc_held = crc_run;
		next_idx = next_idx + 16'd1;
		o.status = ST_OK;
		if (next_idx < held_cnt)
			return;
		active = 0;
		check_frame(o);
	endtask

	task automatic predict_result(input frc_req_t r, output bit has, output frc_rsp_t o);
		int unsigned c, off, p, bsel;
		logic [15:0] idx;
		o   = '0;
		has = 0;
		case (frc_req_e'(r.req_type))
			REQ_READ: begin
				o.read_data = held_byte(r.read_index);
				has = 1;
			end
			REQ_CLEAR: wipe_state();
			REQ_NONE: ;
			default: begin
				c = frag_cnt;
				if (c < ENV_BYTES) begin
					// envelope collection; CRC restarts or resumes at its last byte
					if (c == 0)
						env = '0;
					env[8*c +: 8] = r.data_byte;
					if (c == ENV_BYTES - 1) begin
						crc_run    = (env_word(1) == 0) ? CRC_INIT : crc_held;
						tail_bytes = '0;
						if (env_word(1) != 0 && held_len >= 2)
							tail_bytes = {held_byte(held_len - 2), held_byte(held_len - 1)};
					end
				end else begin
					// data staging with CRC lagging two bytes behind
					off = c - ENV_BYTES;
					idx = env_word(1);
					if (staging_ok() && off < env_word(3)) begin
						p = ((idx == 0) ? 0 : held_len) + off;
						if (p < MAX_FRAME) begin
							bsel = (idx == 0) ? int'(!held_bank) : int'(held_bank);
							store_mem[bsel * MAX_FRAME + p] = r.data_byte;
							written[bsel * MAX_FRAME + p] = 1'b1;
							if (p >= CRC_SKIP)
								crc_run = crc16_next(crc_run, tail_bytes[15:8]);
							tail_bytes = {tail_bytes[7:0], r.data_byte};
						end
					end
				end
				if (!r.last_byte) begin
					if (frag_cnt != CNT_MAX)
						frag_cnt = frag_cnt + 17'd1;
				end else begin
					frag_cnt = '0;
					has = 1;
					close_fragment(c + 1, o);
				end
			end
		endcase
	endtask

	task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			errors++;
			$error("%s: expected 0x%0h, actual 0x%0h", name, e, a);
		end
	endtask

	// Results are compared before the same edge's request is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_state();
			expected_rsp_q.delete();
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				results_seen++;
				if (expected_rsp_q.size() == 0) begin
					errors++;
					$error("result transfer with no result expected");
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (exp_rsp.complete)
						frames_ok++;
					check_field("status", exp_rsp.status, rsp.status);
					check_field("complete", exp_rsp.complete, rsp.complete);
					check_field("frm_len", exp_rsp.frm_len, rsp.frm_len);
					check_field("ver_major", exp_rsp.ver_major, rsp.ver_major);
					check_field("ver_minor", exp_rsp.ver_minor, rsp.ver_minor);
					check_field("msg_kind", exp_rsp.msg_kind, rsp.msg_kind);
					check_field("flag_bits", exp_rsp.flag_bits, rsp.flag_bits);
					check_field("frame_sequence", exp_rsp.frame_sequence, rsp.frame_sequence);
					check_field("time_ms", exp_rsp.time_ms, rsp.time_ms);
					check_field("pay_len", exp_rsp.pay_len, rsp.pay_len);
					check_field("read_data", exp_rsp.read_data, rsp.read_data);
				end
			end
			if (req_valid && req_ready) begin
				predict_result(req, pred_has, pred_rsp);
				if (pred_has)
					expected_rsp_q.push_back(pred_rsp);
			end
			pending = expected_rsp_q.size();
		end
	end

endmodule

// File: sim/tb_fragment_reassembler_frame_checker.sv
`timescale 1ns / 100ps

module tb_fragment_reassembler_frame_checker;
	import frc_pkg::*;

	localparam int MAX_FRAME     = 1040;
	localparam int TOTAL_ITEMS   = 1800;
	localparam int STALL_LIMIT   = 2000;

	typedef enum int {
		FLT_NONE,
		FLT_MAGIC,
		FLT_CRC,
		FLT_SEQ,
		FLT_SKIP,
		FLT_DLEN,
		FLT_ABORT
	} frame_fault_e;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	frc_req_t      req;
	logic          rsp_valid;
	logic          rsp_ready;
	frc_rsp_t      rsp;

	int            errors;
	int            pending;
	int            results_seen;
	int            frames_ok;
	logic [2079:0] written;
	logic          held_bank;

	logic [7:0]    frame_bytes [$];
	bit            gaps_on;
	int            n_items;
	int            n_frames;
	int            stall_left;
	int            quiet_cycles;

	fragment_reassembler_frame_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	frc_frame_scoreboard chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.frames_ok    (frames_ok),
		.written      (written),
		.held_bank    (held_bank)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Result side: random stall bursts while gaps are enabled
	initial begin
		rsp_ready  = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("fragment_reassembler_frame_checker regression: fail");
				$finish;
			end
		end
	end

	function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		return r;
	endfunction

	// One request transfer, with an optional idle burst before it
	task automatic put(frc_req_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
		if (it.req_type != REQ_NONE)
			n_items++;
	endtask

	task automatic put_byte(logic [7:0] b, bit last);
		frc_req_t it;
		it.req_type   = REQ_FRAG;
		it.data_byte  = b;
		it.last_byte  = last;
		it.read_index = 11'($urandom);
		put(it);
	endtask

	task automatic put_other(frc_req_e kind, logic [10:0] ridx);
		frc_req_t it;
		it.req_type   = kind;
		it.data_byte  = 8'($urandom);
		it.last_byte  = 1'($urandom);
		it.read_index = ridx;
		put(it);
	endtask

	// Reads only bytes already written in the held bank, or past the frame end
	task automatic read_some();
		int unsigned pos;
		if ($urandom_range(0, 5) != 0) begin
			for (int t = 0; t < 12; t++) begin
				pos = $urandom_range(0, MAX_FRAME - 1);
				if (written[int'(held_bank) * MAX_FRAME + pos]) begin
					put_other(REQ_READ, 11'(pos));
					return;
				end
			end
		end
		put_other(REQ_READ, 11'($urandom_range(MAX_FRAME, 2047)));
	endtask

	task automatic send_frag(logic [15:0] seq, logic [15:0] idx, logic [15:0] cnt,
			logic [15:0] dlen, int from, int nb);
		logic [63:0] e;
		e = {dlen, cnt, idx, seq};
		for (int k = 0; k < 8 + nb; k++)
			put_byte((k < 8) ? e[8*k +: 8] : frame_bytes[from + k - 8], k == 7 + nb);
	endtask

	task automatic send_noise(int len);
		for (int k = 0; k < len; k++)
			put_byte(8'($urandom), k == len - 1);
	endtask

	// Builds a frame of pl payload bytes, field pl_fld, then sends it in nfrag pieces
	task automatic send_frame(int pl, int pl_fld, int nfrag, frame_fault_e flt);
		logic [15:0] crc, seq, s, ix, dl;
		int len, off, chunk, fi;
		frame_bytes.delete();
		frame_bytes.push_back(FRAME_MAGIC[7:0]);
		frame_bytes.push_back(FRAME_MAGIC[15:8]);
		for (int k = 2; k < 12; k++)
			frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(pl_fld[7:0]);
		frame_bytes.push_back(pl_fld[15:8]);
		for (int k = 0; k < pl; k++)
			frame_bytes.push_back(8'($urandom));
		crc = CRC_INIT;
		for (int k = 2; k < frame_bytes.size(); k++)
			crc = crc16_step(crc, frame_bytes[k]);
		frame_bytes.push_back(crc[7:0]);
		frame_bytes.push_back(crc[15:8]);
		len = frame_bytes.size();
		if (flt == FLT_MAGIC)
			frame_bytes[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
		if (flt == FLT_CRC)
			frame_bytes[$urandom_range(2, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
		seq = 16'($urandom);
		fi  = $urandom_range(0, nfrag - 1);
		off = 0;
		n_frames++;
		for (int i = 0; i < nfrag; i++) begin
			chunk = (i == nfrag - 1) ? len - off : $urandom_range(0, len - off);
			s  = seq;
			ix = 16'(i);
			dl = 16'(chunk);
			if (i == fi && i > 0 && flt == FLT_SEQ)
				s = s + 16'd1;
			if (i == fi && i > 0 && flt == FLT_SKIP)
				ix = ix + 16'd1;
			if (i == fi && flt == FLT_DLEN)
				dl = dl + 16'd1;
			send_frag(s, ix, 16'(nfrag), dl, off, chunk);
			off += chunk;
			if (i == fi && flt == FLT_ABORT)
				return;
		end
	endtask

	initial begin
		int pl, kind;
		frc_req_t idle_req;
		idle_req     = '0;
		req_valid    = 0;
		req          = idle_req;
		arst_n       = 0;
		gaps_on      = 1;
		n_items      = 0;
		n_frames     = 0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes and special cases
		put_other(REQ_READ, 11'd2047);
		put_other(REQ_READ, 11'(MAX_FRAME));
		send_frame(0, 0, 1, FLT_NONE);
		put_other(REQ_READ, 11'd0);
		send_frame(1025, 1025, 2, FLT_NONE);
		send_frame(8, 1025, 1, FLT_NONE);
		send_frame(4, 4, 2, FLT_MAGIC);
		send_frame(4, 4, 2, FLT_CRC);
		send_frame(4, 5, 1, FLT_NONE);
		send_noise(3);
		send_frag(16'h1234, 16'd0, 16'd0, 16'd0, 0, 0);
		send_frag(16'h1234, 16'd2, 16'd2, 16'd0, 0, 0);
		put_other(REQ_CLEAR, 11'd0);
		send_frag(16'hFFFF, 16'd1, 16'd3, 16'd0, 0, 0);
		put_other(REQ_NONE, 11'd0);
		for (int k = 0; k < 8; k++)
			put_byte(8'hFF, k == 7);
		for (int k = 0; k < 8; k++)
			put_byte(8'h00, k == 7);
		send_frame(2, 2, 4, FLT_SKIP);

		// Random: well-formed frames, with faults, reads and noise mixed in
		while (n_items < TOTAL_ITEMS) begin
			if (n_items > TOTAL_ITEMS * 85 / 100)
				gaps_on = 0;
			kind = $urandom_range(0, 99);
			pl = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
			if (kind < 45)
				send_frame(pl, pl, $urandom_range(1, 4), FLT_NONE);
			else if (kind < 60)
				send_frame(pl, pl, $urandom_range(1, 4),
					frame_fault_e'($urandom_range(FLT_MAGIC, FLT_ABORT)));
			else if (kind < 63)
				send_frame(pl, $urandom_range(0, 2047), $urandom_range(1, 3), FLT_NONE);
			else if (kind < 78)
				read_some();
			else if (kind < 80)
				put_other(REQ_CLEAR, 11'($urandom));
			else if (kind < 83)
				put_other(REQ_NONE, 11'($urandom));
			else if (kind < 92)
				send_noise($urandom_range(1, 12));
			else
				send_frag(16'($urandom), 16'($urandom_range(0, 3)),
					16'($urandom_range(0, 3)), 16'd0, 0, 0);
		end
		req_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("covered %0d requests in %0d built frames, overflow and bad envelopes included",
			n_items, n_frames);
		$display("checked %0d results, %0d of them complete frames", results_seen, frames_ok);
		if (errors == 0)
			$display("fragment_reassembler_frame_checker regression: pass");
		else
			$display("fragment_reassembler_frame_checker regression: fail");
		$finish;
	end

endmodule

// File: sim.f
sv/frc_pkg.sv
sv/frc_ram.sv
sv/frc_result_stage.sv
sv/fragment_reassembler_frame_checker.sv
sv/frc_checker.sv
sim/frc_frame_scoreboard.sv
sim/tb_fragment_reassembler_frame_checker.sv
